[rtl/mnota_pkg.sv]
// Shared types, codes and constants for the MIDI note-on trigger and accent block.
package mnota_pkg;

   localparam int VOICE_COUNT_DEFAULT = 16;
   localparam int TABLE_DEPTH         = 16;
   localparam int VOICE_W             = 4;
   localparam int BYTE_W              = 8;
   localparam int MASK_W              = 16;
   localparam int CSR_INDEX_W         = 1;
   localparam int CSR_DATA_W          = 8;

   localparam logic [BYTE_W-1:0] LISTEN_STATUS_RESET   = 8'd152;
   localparam logic [BYTE_W-1:0] VOICE_NOTE_BASE_RESET = 8'd24;

   localparam logic [CSR_INDEX_W-1:0] CSR_LISTEN_STATUS   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOICE_NOTE_BASE = 1'b1;

   localparam logic OP_RX_BYTE   = 1'b0;
   localparam logic OP_SCAN_TICK = 1'b1;

   localparam logic KIND_TRIGGER = 1'b0;
   localparam logic KIND_ACCENT  = 1'b1;

   typedef enum logic [1:0] {
      STAGE_WAIT = 2'd0,
      STAGE_NOTE = 2'd1,
      STAGE_VEL  = 2'd2
   } stage_type;

   typedef struct packed {
      logic              op;
      logic [BYTE_W-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [MASK_W-1:0]  trigger_mask;
      logic [VOICE_W-1:0] voice_index;
      logic [BYTE_W-1:0]  accent_level;
      logic               note_in_range;
   } rsp_type;

   typedef struct packed {
      logic               wr_en;
      logic [VOICE_W-1:0] wr_voice;
      logic [BYTE_W-1:0]  wr_level;
   } table_wr_type;

endpackage

[rtl/midi_note_on_trigger_accent.sv]
// Top level of the MIDI note-on trigger and accent block.
//
//   channel  direction  handshake          payload
//   req_     in         req_valid/stall    mnota_pkg::req_type (op, rx_byte)
//   rsp_     out        rsp_valid/stall    mnota_pkg::rsp_type
//   csr_     in         csr_write_enable   csr_index, csr_wdata
//
// One request is taken per cycle while req_stall is low; its result, if any, shows in
// the next cycle from a single output register.
// The output register sets the rate: req_stall rises only while it holds a
// result and rsp_stall is high.
// Synchronous active-high reset clears the parser, scan pointer, accent table
// and output valid; no clearing pass is needed.
module midi_note_on_trigger_accent #(
   parameter int VOICE_COUNT = mnota_pkg::VOICE_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  mnota_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mnota_pkg::rsp_type                rsp_data,
   input  logic                              csr_write_enable,
   input  logic [mnota_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mnota_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [mnota_pkg::BYTE_W-1:0]  listen_status_ff;
   logic [mnota_pkg::BYTE_W-1:0]  note_base_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   mnota_pkg::rsp_type            rsp_data_ff, rsp_data_in;
   logic                          req_take;
   logic                          byte_en;
   logic                          scan_en;
   logic                          trig_valid;
   mnota_pkg::rsp_type            trig_rsp;
   mnota_pkg::table_wr_type       table_wr;
   logic [mnota_pkg::VOICE_W-1:0] scan_index;
   logic [mnota_pkg::BYTE_W-1:0]  scan_level;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;
   assign byte_en   = req_take & (req_data.op == mnota_pkg::OP_RX_BYTE);
   assign scan_en   = req_take & (req_data.op == mnota_pkg::OP_SCAN_TICK);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   mnota_parser #(
      .VOICE_COUNT(VOICE_COUNT)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .byte_en       (byte_en),
      .rx_byte       (req_data.rx_byte),
      .listen_status (listen_status_ff),
      .note_base     (note_base_ff),
      .trig_valid    (trig_valid),
      .trig_rsp      (trig_rsp),
      .table_wr      (table_wr)
   );

   mnota_accent #(
      .VOICE_COUNT(VOICE_COUNT)
   ) u_accent (
      .clock      (clock),
      .reset      (reset),
      .scan_en    (scan_en),
      .table_wr   (table_wr),
      .scan_index (scan_index),
      .scan_level (scan_level)
   );

   // load a new result, drain a taken one, hold a stalled one
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (scan_en) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in              = '0;
         rsp_data_in.kind         = mnota_pkg::KIND_ACCENT;
         rsp_data_in.voice_index  = scan_index;
         rsp_data_in.accent_level = scan_level;
      end else if (trig_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = trig_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         listen_status_ff <= mnota_pkg::LISTEN_STATUS_RESET;
         note_base_ff     <= mnota_pkg::VOICE_NOTE_BASE_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               mnota_pkg::CSR_LISTEN_STATUS:   listen_status_ff <= csr_wdata;
               mnota_pkg::CSR_VOICE_NOTE_BASE: note_base_ff     <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[rtl/mnota_parser.sv]
// Three-stage note-on parser: status match, note to trigger mask, velocity to table write.
module mnota_parser #(
   parameter int VOICE_COUNT = mnota_pkg::VOICE_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          byte_en,
   input  logic [mnota_pkg::BYTE_W-1:0]  rx_byte,
   input  logic [mnota_pkg::BYTE_W-1:0]  listen_status,
   input  logic [mnota_pkg::BYTE_W-1:0]  note_base,
   output logic                          trig_valid,
   output mnota_pkg::rsp_type            trig_rsp,
   output mnota_pkg::table_wr_type       table_wr
);

   localparam logic [mnota_pkg::BYTE_W-1:0] VOICE_LIMIT = mnota_pkg::BYTE_W'(VOICE_COUNT);

   mnota_pkg::stage_type                  stage_ff, stage_in;
   logic [mnota_pkg::VOICE_W-1:0]         pending_voice_ff, pending_voice_in;
   logic                                  pending_valid_ff, pending_valid_in;
   logic [mnota_pkg::BYTE_W-1:0]          voice_offset;
   logic                                  in_range;

   assign voice_offset = rx_byte - note_base;
   assign in_range     = (voice_offset < VOICE_LIMIT);

   // next state
   always_comb begin
      stage_in = stage_ff;
      if (byte_en) begin
         case (stage_ff)
            mnota_pkg::STAGE_WAIT: begin
               if (rx_byte == listen_status) begin
                  stage_in = mnota_pkg::STAGE_NOTE;
               end
            end
            mnota_pkg::STAGE_NOTE: stage_in = mnota_pkg::STAGE_VEL;
            mnota_pkg::STAGE_VEL:  stage_in = mnota_pkg::STAGE_WAIT;
            default:               stage_in = mnota_pkg::STAGE_WAIT;
         endcase
      end
   end

   // outputs
   always_comb begin
      pending_voice_in       = pending_voice_ff;
      pending_valid_in       = pending_valid_ff;
      trig_valid             = 1'b0;
      trig_rsp               = '0;
      trig_rsp.kind          = mnota_pkg::KIND_TRIGGER;
      table_wr.wr_en         = 1'b0;
      table_wr.wr_voice      = pending_voice_ff;
      table_wr.wr_level      = rx_byte;
      if (byte_en) begin
         case (stage_ff)
            mnota_pkg::STAGE_NOTE: begin
               trig_valid             = 1'b1;
               pending_valid_in       = in_range;
               trig_rsp.note_in_range = in_range;
               if (in_range) begin
                  pending_voice_in      = voice_offset[mnota_pkg::VOICE_W-1:0];
                  trig_rsp.trigger_mask =
                     mnota_pkg::MASK_W'(1) << voice_offset[mnota_pkg::VOICE_W-1:0];
               end
            end
            mnota_pkg::STAGE_VEL: begin
               table_wr.wr_en = pending_valid_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff         <= mnota_pkg::STAGE_WAIT;
         pending_voice_ff <= '0;
         pending_valid_ff <= 1'b0;
      end else begin
         stage_ff         <= stage_in;
         pending_voice_ff <= pending_voice_in;
         pending_valid_ff <= pending_valid_in;
      end
   end

endmodule

[rtl/mnota_accent.sv]
// Accent level table with round-robin scan pointer.
module mnota_accent #(
   parameter int VOICE_COUNT = mnota_pkg::VOICE_COUNT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           scan_en,
   input  mnota_pkg::table_wr_type        table_wr,
   output logic [mnota_pkg::VOICE_W-1:0]  scan_index,
   output logic [mnota_pkg::BYTE_W-1:0]   scan_level
);

   localparam logic [mnota_pkg::VOICE_W-1:0] LAST_VOICE = mnota_pkg::VOICE_W'(VOICE_COUNT - 1);

   logic [mnota_pkg::BYTE_W-1:0]  table_ff [mnota_pkg::TABLE_DEPTH];
   logic [mnota_pkg::VOICE_W-1:0] ptr_ff, ptr_in;

   assign scan_index = ptr_ff;
   assign scan_level = table_ff[ptr_ff];

   always_comb begin
      ptr_in = ptr_ff;
      if (scan_en) begin
         if (ptr_ff == LAST_VOICE) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         for (int i = 0; i < mnota_pkg::TABLE_DEPTH; i++) begin
            table_ff[i] <= '0;
         end
      end else begin
         ptr_ff <= ptr_in;
         if (table_wr.wr_en) begin
            table_ff[table_wr.wr_voice] <= table_wr.wr_level;
         end
      end
   end

endmodule

[rtl/mnota_checker.sv]
// Port-level checks for the MIDI note-on trigger and accent block, with bind.
module mnota_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input mnota_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input mnota_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a blocked response");

   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.op == mnota_pkg::OP_SCAN_TICK
      |=> rsp_valid && rsp_data.kind == mnota_pkg::KIND_ACCENT)
      else $error("scan tick gave no accent response");

   a_mask_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == mnota_pkg::KIND_TRIGGER
      |-> $onehot0(rsp_data.trigger_mask)
          && (rsp_data.note_in_range == (rsp_data.trigger_mask != '0)))
      else $error("trigger mask inconsistent with range flag");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind midi_note_on_trigger_accent mnota_checker u_mnota_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[verif/tb_top.sv]
// Self-checking testbench for the MIDI note-on trigger and accent block.
module tb_top;
   import mnota_pkg::*;

   localparam int NUM_VOICES   = VOICE_COUNT_DEFAULT;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 4;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   req_type                req_data         = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata        = '0;

   req_type midi_in_q[$];
   rsp_type rsp_expect_q[$];

   int idle_pct       = 0;
   int stall_pct      = 0;
   int queued_count   = 0;
   int taken_count    = 0;
   int checked_count  = 0;
   int in_range_count = 0;
   int level_count    = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   bit req_fire       = 1'b0;

   stage_type          parser_stage;
   logic [VOICE_W-1:0] held_voice;
   bit                 held_ok;
   logic [BYTE_W-1:0]  level_table [TABLE_DEPTH];
   logic [VOICE_W-1:0] scan_voice;
   logic [BYTE_W-1:0]  match_status;
   logic [BYTE_W-1:0]  note_base;

   always #5 clock = ~clock;

   midi_note_on_trigger_accent #(.VOICE_COUNT(NUM_VOICES)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   task automatic predict_parser(input req_type r);
      rsp_type           e;
      logic [BYTE_W-1:0] v;
      e = '0;
      if (r.op == OP_SCAN_TICK) begin
         e.kind         = KIND_ACCENT;
         e.voice_index  = scan_voice;
         e.accent_level = level_table[scan_voice];
         if (int'(scan_voice) + 1 >= NUM_VOICES || scan_voice == 4'hF) begin
            scan_voice = '0;
         end else begin
            scan_voice = scan_voice + 1'b1;
         end
         rsp_expect_q.push_back(e);
      end else begin
         case (parser_stage)
            STAGE_WAIT: begin
               if (r.rx_byte == match_status) parser_stage = STAGE_NOTE;
            end
            STAGE_NOTE: begin
               v            = r.rx_byte - note_base;
               parser_stage = STAGE_VEL;
               e.kind       = KIND_TRIGGER;
               if (v < NUM_VOICES) begin
                  held_voice      = v[VOICE_W-1:0];
                  held_ok         = 1'b1;
                  e.trigger_mask  = 16'h0001 << v;
                  e.note_in_range = 1'b1;
               end else begin
                  held_ok = 1'b0;
               end
               rsp_expect_q.push_back(e);
            end
            STAGE_VEL: begin
               if (held_ok) level_table[held_voice] = r.rx_byte;
               parser_stage = STAGE_WAIT;
            end
            default: parser_stage = STAGE_WAIT;
         endcase
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      if (reset) begin
         parser_stage = STAGE_WAIT;
         held_voice   = '0;
         held_ok      = 1'b0;
         scan_voice   = '0;
         match_status = LISTEN_STATUS_RESET;
         note_base    = VOICE_NOTE_BASE_RESET;
         req_fire     = 1'b0;
         for (int i = 0; i < TABLE_DEPTH; i++) level_table[i] = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_expect_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: %p", rsp_data);
            end else begin
               want = rsp_expect_q.pop_front();
               checked_count++;
               if (want.kind == KIND_ACCENT) level_count++;
               else if (want.note_in_range) in_range_count++;
               if (rsp_data.kind != want.kind
                   || rsp_data.trigger_mask != want.trigger_mask
                   || rsp_data.voice_index != want.voice_index
                   || rsp_data.accent_level != want.accent_level
                   || rsp_data.note_in_range != want.note_in_range) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch exp kind=%0d mask=%h voice=%0d level=%h in_range=%0d",
                              want.kind, want.trigger_mask, want.voice_index,
                              want.accent_level, want.note_in_range);
                     $display("         got kind=%0d mask=%h voice=%0d level=%h in_range=%0d",
                              rsp_data.kind, rsp_data.trigger_mask, rsp_data.voice_index,
                              rsp_data.accent_level, rsp_data.note_in_range);
                  end
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_LISTEN_STATUS:   match_status = csr_wdata;
               CSR_VOICE_NOTE_BASE: note_base    = csr_wdata;
               default: ;
            endcase
         end
         req_fire = req_valid && !req_stall;
         if (req_fire) begin
            taken_count++;
            predict_parser(req_data);
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped at cycle limit %0d", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_fire) begin
            if (midi_in_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= midi_in_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   function automatic void queue_byte(input logic [BYTE_W-1:0] b);
      req_type r;
      r.op      = OP_RX_BYTE;
      r.rx_byte = b;
      midi_in_q.push_back(r);
      queued_count++;
   endfunction

   function automatic void queue_tick();
      req_type r;
      r.op      = OP_SCAN_TICK;
      r.rx_byte = 8'($urandom_range(0, 255));
      midi_in_q.push_back(r);
      queued_count++;
   endfunction

   task automatic wait_drained();
      while (midi_in_q.size() != 0 || taken_count != queued_count || rsp_expect_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(input int idle, input int stall, input logic [BYTE_W-1:0] status,
                            input logic [BYTE_W-1:0] base, input int count);
      int made;
      int pick;
      made = 0;
      write_csr(CSR_LISTEN_STATUS, status);
      write_csr(CSR_VOICE_NOTE_BASE, base);
      idle_pct  = idle;
      stall_pct = stall;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            queue_byte(status);
            if ($urandom_range(0, 4) == 0) begin
               queue_tick();
               made++;
            end
            if ($urandom_range(0, 3) == 0) queue_byte(8'($urandom_range(0, 255)));
            else queue_byte(8'(base + $urandom_range(0, NUM_VOICES + 3)));
            if ($urandom_range(0, 4) == 0) begin
               queue_tick();
               made++;
            end
            queue_byte(8'($urandom_range(0, 255)));
            made += 3;
         end else if (pick < 80) begin
            queue_tick();
            made++;
         end else if (pick < 90) begin
            queue_byte(8'($urandom_range(0, 255)));
            made++;
         end else begin
            // drop the velocity: the next byte lands in its place
            queue_byte(status);
            queue_byte(8'(base + $urandom_range(0, NUM_VOICES - 1)));
            made += 2;
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_tick();
      queue_tick();
      queue_byte(LISTEN_STATUS_RESET);
      queue_byte(VOICE_NOTE_BASE_RESET);
      queue_byte(8'h7F);
      queue_byte(LISTEN_STATUS_RESET);
      queue_byte(VOICE_NOTE_BASE_RESET + 8'd15);
      queue_byte(8'hFF);
      queue_byte(LISTEN_STATUS_RESET);
      queue_byte(VOICE_NOTE_BASE_RESET - 8'd1);
      queue_byte(8'h01);
      queue_byte(LISTEN_STATUS_RESET);
      queue_byte(VOICE_NOTE_BASE_RESET + 8'd16);
      queue_byte(8'h05);
      queue_byte(LISTEN_STATUS_RESET - 8'd1);
      queue_byte(LISTEN_STATUS_RESET + 8'd1);
      queue_byte(LISTEN_STATUS_RESET);
      queue_byte(LISTEN_STATUS_RESET);
      queue_byte(8'h00);
      queue_byte(LISTEN_STATUS_RESET);
      queue_tick();
      queue_byte(VOICE_NOTE_BASE_RESET + 8'd6);
      queue_tick();
      queue_byte(8'h80);
      queue_tick();
      queue_tick();
      wait_drained();

      run_phase(0,  0,  8'h90, 8'h00, 380);
      run_phase(46, 0,  8'hFF, 8'hFF, 380);
      run_phase(0,  46, 8'h00, 8'h70, 380);
      run_phase(22, 22, 8'h9F, 8'h18, 380);

      $display("Covered %0d requests over five status/base settings and four idle mixes.",
               taken_count);
      $display("Checked %0d results: %0d in-range triggers, %0d accent reads, %0d mismatches.",
               checked_count, in_range_count, level_count, mismatch_count);
      if (mismatch_count == 0 && rsp_expect_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/mnota_pkg.sv
rtl/mnota_parser.sv
rtl/mnota_accent.sv
rtl/midi_note_on_trigger_accent.sv
rtl/mnota_checker.sv
verif/tb_top.sv
